// ===== hdl/box_smooth_3x3_rgb_assert.svh =====
// assertion macros for the 3x3 box smoother
// used by box_smooth_3x3_rgb; expects clk and rst_n in the including scope
`ifndef BOX_SMOOTH_3X3_RGB_ASSERT_SVH
`define BOX_SMOOTH_3X3_RGB_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BSR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/bsr_pkg.sv =====
// types and fixed constants of the 3x3 box smoother
// no dependencies; used by box_smooth_3x3_rgb
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int CH_W      = 16;   // bits per colour channel
    localparam int NUM_CH    = 3;    // red, green, blue
    localparam int CFG_W     = 11;   // side_length register width
    localparam int ROWCOL_W  = 10;   // out_row / out_col width
    localparam int COL_W     = 18;   // sum of three channel values
    localparam int SUM_W     = 20;   // sum of nine channel values
    localparam int CNT_W     = 4;    // window pixel count, 1..9
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W   = RECIP_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam logic [CFG_W-1:0] SIDE_RESET = CFG_W'(64);

    // floor(2^20 / n) for the window counts that can occur
    localparam int RECIP_ONE = 1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'(RECIP_ONE);
    localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'(RECIP_ONE / 2);
    localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'(RECIP_ONE / 3);
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(RECIP_ONE / 4);
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(RECIP_ONE / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(RECIP_ONE / 9);

    // channel 0 (red) in the low bits, then green, then blue
    typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] r;
        case (cnt)
            CNT_W'(2): r = RECIP_2;
            CNT_W'(3): r = RECIP_3;
            CNT_W'(4): r = RECIP_4;
            CNT_W'(6): r = RECIP_6;
            CNT_W'(9): r = RECIP_9;
            default:   r = RECIP_1;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/box_smooth_3x3_rgb.sv =====
// top level of the streaming 3x3 box smoother for square rgb images
// depends on bsr_pkg and box_smooth_3x3_rgb_assert.svh
`timescale 1ns / 1ps

// Streaming 3x3 box smoother. Pixels of a square image (side set by
// side_length, 0 acts as 1, values above MAX_SIDE act as MAX_SIDE) enter in
// raster order on the in_* channel; each result carries the floor of the
// per-channel mean over the 3x3 window clipped to the image, plus its
// row/column, frame_done on the bottom-right pixel and run_last on the last
// result that an input item releases (0 to 4 results per item). Two line
// buffers, one single-port synchronous memory each, hold the previous two
// rows: both are read when an item is accepted and written back on the
// following cycle, and the next item is taken only after that write, so
// read and write of the same entry never overlap. Line entries are read
// only after being written in the current frame, so no clearing pass is
// needed after reset. An item that releases no result ends at the write-back;
// each result then passes column sums, total, reciprocal multiply and
// remainder correction, waiting there while the single output register is
// full and out_ready is low. A new item can be accepted while the last
// result of the previous one still waits in the output register. Writing
// side_length restarts the frame at row 0, column 0; write it only while idle.

module box_smooth_3x3_rgb #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [bsr_pkg::CFG_W-1:0]     cfg_data,
    // pixel input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bsr_pkg::CH_W-1:0]      in_red,
    input  logic [bsr_pkg::CH_W-1:0]      in_green,
    input  logic [bsr_pkg::CH_W-1:0]      in_blue,
    // smoothed output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bsr_pkg::CH_W-1:0]      out_red,
    output logic [bsr_pkg::CH_W-1:0]      out_green,
    output logic [bsr_pkg::CH_W-1:0]      out_blue,
    output logic [bsr_pkg::ROWCOL_W-1:0]  out_row,
    output logic [bsr_pkg::ROWCOL_W-1:0]  out_col,
    output logic                          frame_done,
    output logic                          run_last
);

    localparam int POS_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W  = (bsr_pkg::CFG_W > SIDE_W) ? bsr_pkg::CFG_W : SIDE_W;

    typedef enum logic [2:0] {
        S_IDLE,   // waiting for an item
        S_WR,     // line data back from memory, write-back
        S_COL,    // per-column masked sums
        S_TOT,    // window total and reciprocal
        S_MUL,    // reciprocal multiply
        S_FIX     // remainder correction, load output register
    } state_t;

    state_t state_reg;

    // control state
    logic [bsr_pkg::CFG_W-1:0] side_length_reg;
    logic [POS_W-1:0]          row_pos_reg;
    logic [POS_W-1:0]          col_pos_reg;
    logic                      row_idx_reg;   // which of up to two result rows
    logic                      col_idx_reg;   // which of up to two result columns
    logic                      out_valid_reg;

    // datapath
    bsr_pkg::pix_t pix_reg;
    bsr_pkg::pix_t newer_rd_reg;
    bsr_pkg::pix_t older_rd_reg;
    bsr_pkg::pix_t win_reg [6];   // [0..2] column ic-2, [3..5] column ic-1

    bsr_pkg::pix_t newer_mem [MAX_SIDE];
    bsr_pkg::pix_t older_mem [MAX_SIDE];

    logic [bsr_pkg::COL_W-1:0]   col_sum_reg [3][bsr_pkg::NUM_CH];
    logic [bsr_pkg::SUM_W-1:0]   tot_reg     [bsr_pkg::NUM_CH];
    logic [bsr_pkg::SUM_W-1:0]   q0_reg      [bsr_pkg::NUM_CH];
    logic [bsr_pkg::CNT_W-1:0]   cnt_reg;
    logic [bsr_pkg::RECIP_W-1:0] recip_reg;

    logic [bsr_pkg::CH_W-1:0]     out_red_reg;
    logic [bsr_pkg::CH_W-1:0]     out_green_reg;
    logic [bsr_pkg::CH_W-1:0]     out_blue_reg;
    logic [bsr_pkg::ROWCOL_W-1:0] out_row_reg;
    logic [bsr_pkg::ROWCOL_W-1:0] out_col_reg;
    logic                         frame_done_reg;
    logic                         run_last_reg;

    // ------------------------------------------------------------------
    // effective side and result selection
    // ------------------------------------------------------------------
    logic [SIDE_W-1:0] side_eff;
    logic [POS_W-1:0]  last_idx;

    always_comb
    begin
        if (side_length_reg == '0)
            side_eff = SIDE_W'(1);
        else if (CMP_W'(side_length_reg) > CMP_W'(MAX_SIDE))
            side_eff = SIDE_W'(MAX_SIDE);
        else
            side_eff = SIDE_W'(side_length_reg);
        last_idx = POS_W'(side_eff - SIDE_W'(1));
    end

    logic       in_fire;
    logic       out_free;
    logic       row_first;      // current item is in row 0
    logic       col_first;      // current item is in column 0
    logic [1:0] row_n;          // number of result rows this item releases
    logic [1:0] col_n;          // number of result columns this item releases
    logic       has_results;
    logic       row_cur;        // selected result row is the input row itself
    logic       col_cur;        // selected result column is the input column itself
    logic       last_row_sel;
    logic       last_col_sel;
    logic       last_result;
    logic       step_end;
    logic [POS_W-1:0] res_row;
    logic [POS_W-1:0] res_col;
    logic [2:0] row_mask;       // indexed by rows above the input, 0..2
    logic [2:0] col_mask;       // indexed by columns left of the input, 0..2

    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign row_first = (row_pos_reg == '0);
    assign col_first = (col_pos_reg == '0);

    always_comb
    begin
        row_n = 2'(!row_first) + 2'(row_pos_reg == last_idx);
        col_n = 2'(!col_first) + 2'(col_pos_reg == last_idx);
        has_results = (row_n != 2'd0) && (col_n != 2'd0);

        // in row 0 only the input row itself can be a result row
        row_cur = row_idx_reg || row_first;
        col_cur = col_idx_reg || col_first;
        last_row_sel = ({1'b0, row_idx_reg} == (row_n - 2'd1));
        last_col_sel = ({1'b0, col_idx_reg} == (col_n - 2'd1));
        last_result  = last_row_sel && last_col_sel;

        res_row = row_cur ? row_pos_reg : (row_pos_reg - POS_W'(1));
        res_col = col_cur ? col_pos_reg : (col_pos_reg - POS_W'(1));

        // a row two above is inside the window only for the row above the input
        row_mask[0] = 1'b1;
        row_mask[1] = !row_first;
        row_mask[2] = (row_pos_reg > POS_W'(1)) && !row_cur;
        col_mask[0] = 1'b1;
        col_mask[1] = !col_first;
        col_mask[2] = (col_pos_reg > POS_W'(1)) && !col_cur;

        step_end = ((state_reg == S_WR) && !has_results)
                || ((state_reg == S_FIX) && out_free && last_result);
    end

    // ------------------------------------------------------------------
    // window taps and column sums
    // ------------------------------------------------------------------
    bsr_pkg::pix_t cur [3];
    bsr_pkg::pix_t tap [3][3];   // [rows above][columns left]
    logic [bsr_pkg::COL_W-1:0] col_sum [3][bsr_pkg::NUM_CH];
    logic [bsr_pkg::CNT_W-1:0] win_cnt;

    always_comb
    begin
        logic [1:0] rcount;
        logic [1:0] ccount;
        cur[0] = pix_reg;
        cur[1] = newer_rd_reg;
        cur[2] = older_rd_reg;
        for (int dr = 0; dr < 3; dr++)
        begin
            tap[dr][0] = cur[dr];
            tap[dr][1] = win_reg[3 + dr];
            tap[dr][2] = win_reg[dr];
        end
        for (int dc = 0; dc < 3; dc++)
        begin
            for (int ch = 0; ch < bsr_pkg::NUM_CH; ch++)
            begin
                col_sum[dc][ch] = '0;
                for (int dr = 0; dr < 3; dr++)
                begin
                    if (row_mask[dr] && col_mask[dc])
                        col_sum[dc][ch] = col_sum[dc][ch]
                                        + bsr_pkg::COL_W'(tap[dr][dc][ch]);
                end
            end
        end
        rcount  = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
        ccount  = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);
        win_cnt = bsr_pkg::CNT_W'(rcount) * bsr_pkg::CNT_W'(ccount);
    end

    // remainder correction: q0 is the true quotient or one below it
    logic [bsr_pkg::SUM_W-1:0] quot [bsr_pkg::NUM_CH];

    always_comb
    begin
        logic [bsr_pkg::SUM_W-1:0] rem;
        for (int ch = 0; ch < bsr_pkg::NUM_CH; ch++)
        begin
            rem = tot_reg[ch]
                - bsr_pkg::SUM_W'(q0_reg[ch] * bsr_pkg::SUM_W'(cnt_reg));
            quot[ch] = q0_reg[ch]
                     + bsr_pkg::SUM_W'(rem >= bsr_pkg::SUM_W'(cnt_reg));
        end
    end

    // ------------------------------------------------------------------
    // line buffers: read on accept, write back in S_WR
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WR)
            newer_mem[col_pos_reg] <= pix_reg;
        if (in_fire)
            newer_rd_reg <= newer_mem[col_pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WR) && !row_first)
            older_mem[col_pos_reg] <= newer_rd_reg;
        if (in_fire)
            older_rd_reg <= older_mem[col_pos_reg];
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pix_reg[0] <= in_red;
            pix_reg[1] <= in_green;
            pix_reg[2] <= in_blue;
        end

        if (state_reg == S_COL)
        begin
            col_sum_reg <= col_sum;
            cnt_reg     <= win_cnt;
        end

        if (state_reg == S_TOT)
        begin
            for (int ch = 0; ch < bsr_pkg::NUM_CH; ch++)
                tot_reg[ch] <= bsr_pkg::SUM_W'(col_sum_reg[0][ch])
                             + bsr_pkg::SUM_W'(col_sum_reg[1][ch])
                             + bsr_pkg::SUM_W'(col_sum_reg[2][ch]);
            recip_reg <= bsr_pkg::recip_of(cnt_reg);
        end

        if (state_reg == S_MUL)
        begin
            for (int ch = 0; ch < bsr_pkg::NUM_CH; ch++)
                q0_reg[ch] <= bsr_pkg::SUM_W'(
                    (bsr_pkg::PROD_W'(tot_reg[ch]) * bsr_pkg::PROD_W'(recip_reg))
                    >> bsr_pkg::RECIP_SHIFT);
        end

        if ((state_reg == S_FIX) && out_free)
        begin
            out_red_reg    <= bsr_pkg::CH_W'(quot[0]);
            out_green_reg  <= bsr_pkg::CH_W'(quot[1]);
            out_blue_reg   <= bsr_pkg::CH_W'(quot[2]);
            out_row_reg    <= bsr_pkg::ROWCOL_W'(res_row);
            out_col_reg    <= bsr_pkg::ROWCOL_W'(res_col);
            frame_done_reg <= (res_row == last_idx) && (res_col == last_idx);
            run_last_reg   <= last_result;
        end

        // shift the window once all results of the item have gone
        if (step_end)
        begin
            for (int a = 0; a < 3; a++)
            begin
                win_reg[a]     <= win_reg[3 + a];
                win_reg[3 + a] <= cur[a];
            end
        end
    end

    // ------------------------------------------------------------------
    // control: state machine, position, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            side_length_reg <= bsr_pkg::SIDE_RESET;
            row_pos_reg     <= '0;
            col_pos_reg     <= '0;
            row_idx_reg     <= 1'b0;
            col_idx_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                        state_reg <= S_WR;
                end
                S_WR:
                begin
                    row_idx_reg <= 1'b0;
                    col_idx_reg <= 1'b0;
                    state_reg   <= has_results ? S_COL : S_IDLE;
                end
                S_COL:
                    state_reg <= S_TOT;
                S_TOT:
                    state_reg <= S_MUL;
                S_MUL:
                    state_reg <= S_FIX;
                S_FIX:
                begin
                    if (out_free)
                    begin
                        if (last_result)
                            state_reg <= S_IDLE;
                        else
                        begin
                            state_reg <= S_COL;
                            if (last_col_sel)
                            begin
                                col_idx_reg <= 1'b0;
                                row_idx_reg <= 1'b1;
                            end
                            else
                                col_idx_reg <= 1'b1;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            // output register: load wins over a simultaneous take
            if ((state_reg == S_FIX) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                side_length_reg <= cfg_data;
                row_pos_reg     <= '0;
                col_pos_reg     <= '0;
            end
            else if (step_end)
            begin
                if (col_pos_reg == last_idx)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= (row_pos_reg == last_idx) ? '0
                                 : (row_pos_reg + POS_W'(1));
                end
                else
                    col_pos_reg <= col_pos_reg + POS_W'(1);
            end
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign out_row    = out_row_reg;
    assign out_col    = out_col_reg;
    assign frame_done = frame_done_reg;
    assign run_last   = run_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "box_smooth_3x3_rgb_assert.svh"

    // an accepted item always reaches the write-back cycle next
    `BSR_ASSERT_NEXT(a_accept_writeback, in_valid && in_ready, state_reg == S_WR, "write-back skipped after accept")

    // only the clipped window sizes can reach the correction stage
    `BSR_ASSERT_IMPL(a_count_legal, state_reg == S_FIX, cnt_reg == 1 || cnt_reg == 2 || cnt_reg == 3 || cnt_reg == 4 || cnt_reg == 6 || cnt_reg == 9, "illegal window count")

    // the bottom-right result is the last of its item and lies on the diagonal
    `BSR_ASSERT_IMPL(a_frame_done_last, out_valid && frame_done, run_last && (out_row == out_col), "frame_done on a result that is not final")

endmodule
